/* rtl/qdt_pkg.sv */
// Shared constants and types for the quadruple dedup table.
package qdt_pkg;

    localparam int OP_W        = 4;
    localparam int SYM_PORT_W  = 8;
    localparam int SLOT_PORT_W = 7;

    // Control that travels with a lookup token along the cell chain
    typedef struct packed {
        logic vld;
        logic last;
        logic hit;
    } t_tok_ctl;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

/* rtl/qdt_cell.sv */
// One table cell: holds a stored triple and compares the passing lookup token.
module qdt_cell #(
    parameter int SYM_W  = 8,
    parameter int SLOT_W = 7,
    parameter int CNT_W  = 8,
    parameter int IDX    = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Occupancy and table write
    input  logic [CNT_W-1:0]             i_count,
    input  logic                         i_wr_en,
    input  logic [SLOT_W-1:0]            i_wr_slot,
    input  logic [qdt_pkg::OP_W-1:0]     i_wr_op,
    input  logic [SYM_W-1:0]             i_wr_a1,
    input  logic [SYM_W-1:0]             i_wr_a2,
    input  logic [SYM_W-1:0]             i_wr_dst,
    // Token from left neighbor
    input  qdt_pkg::t_tok_ctl            i_ctl,
    input  logic [qdt_pkg::OP_W-1:0]     i_op,
    input  logic [SYM_W-1:0]             i_a1,
    input  logic [SYM_W-1:0]             i_a2,
    input  logic [SYM_W-1:0]             i_dst,
    input  logic [SLOT_W-1:0]            i_slot,
    input  logic [SYM_W-1:0]             i_repl,
    // Token to right neighbor
    output qdt_pkg::t_tok_ctl            o_ctl,
    output logic [qdt_pkg::OP_W-1:0]     o_op,
    output logic [SYM_W-1:0]             o_a1,
    output logic [SYM_W-1:0]             o_a2,
    output logic [SYM_W-1:0]             o_dst,
    output logic [SLOT_W-1:0]            o_slot,
    output logic [SYM_W-1:0]             o_repl
);
    import qdt_pkg::*;

    logic [OP_W-1:0]   r_ent_op;
    logic [SYM_W-1:0]  r_ent_a1;
    logic [SYM_W-1:0]  r_ent_a2;
    logic [SYM_W-1:0]  r_ent_dst;

    t_tok_ctl          r_ctl;
    t_tok_ctl          n_ctl;
    logic [OP_W-1:0]   r_op;
    logic [SYM_W-1:0]  r_a1;
    logic [SYM_W-1:0]  r_a2;
    logic [SYM_W-1:0]  r_dst;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [SYM_W-1:0]  r_repl;
    logic [SYM_W-1:0]  n_repl;

    logic              w_occupied;
    logic              w_match;

    assign w_occupied = CNT_W'(IDX) < i_count;
    assign w_match    = w_occupied && (r_ent_op == i_op) && (r_ent_a1 == i_a1)
                        && (r_ent_a2 == i_a2);

    // First match along the chain is the lowest slot; later cells leave it alone
    always_comb begin
        n_ctl  = i_ctl;
        n_slot = i_slot;
        n_repl = i_repl;
        if (i_ctl.vld && !i_ctl.hit && w_match) begin
            n_ctl.hit = 1'b1;
            n_slot    = SLOT_W'(IDX);
            n_repl    = r_ent_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_slot == SLOT_W'(IDX))) begin
            r_ent_op  <= i_wr_op;
            r_ent_a1  <= i_wr_a1;
            r_ent_a2  <= i_wr_a2;
            r_ent_dst <= i_wr_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= i_op;
        r_a1   <= i_a1;
        r_a2   <= i_a2;
        r_dst  <= i_dst;
        r_slot <= n_slot;
        r_repl <= n_repl;
    end

    assign o_ctl  = r_ctl;
    assign o_op   = r_op;
    assign o_a1   = r_a1;
    assign o_a2   = r_a2;
    assign o_dst  = r_dst;
    assign o_slot = r_slot;
    assign o_repl = r_repl;

endmodule

/* rtl/quad_dedup_table.sv */
// Top level of the quadruple dedup table: cell chain, result stage and fill count.
//
//   channel  direction  handshake                   payload
//   in       into block i_in_valid / o_in_stall     opcode_id, first_arg, second_arg,
//                                                   dest_name, last_item
//   out      from block o_out_valid / i_out_stall   kept, matched, match_slot,
//                                                   replace_with, table_overflow, echoes
//
// An item is taken in, then its lookup token walks the cell chain one cell per cycle;
// the tail is then latched, and the result and table write are committed once the output
// register is empty or not stalled; only then is the next item taken.
// A finished result sits in the output register, so the next item is taken while it waits.
// Reset clears the fill count and the token valids; stored entries are not cleared.
// A last-item mark empties the table after its own result is committed.
module quad_dedup_table #(
    parameter int TABLE_DEPTH = 128,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [qdt_pkg::OP_W-1:0]            i_opcode_id,
    input  logic [qdt_pkg::SYM_PORT_W-1:0]      i_first_arg,
    input  logic [qdt_pkg::SYM_PORT_W-1:0]      i_second_arg,
    input  logic [qdt_pkg::SYM_PORT_W-1:0]      i_dest_name,
    input  logic                                i_last_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_kept,
    output logic                                o_matched,
    output logic [qdt_pkg::SLOT_PORT_W-1:0]     o_match_slot,
    output logic [qdt_pkg::SYM_PORT_W-1:0]      o_replace_with,
    output logic                                o_table_overflow,
    output logic [qdt_pkg::OP_W-1:0]            o_out_opcode,
    output logic [qdt_pkg::SYM_PORT_W-1:0]      o_out_first_arg,
    output logic [qdt_pkg::SYM_PORT_W-1:0]      o_out_second_arg,
    output logic [qdt_pkg::SYM_PORT_W-1:0]      o_out_dest
);
    import qdt_pkg::*;

    localparam int SYM_W  = (SYMBOL_BITS < SYM_PORT_W) ? SYMBOL_BITS : SYM_PORT_W;
    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // Token chain wiring; index 0 is fed from the input ports
    t_tok_ctl          w_ctl  [TABLE_DEPTH+1];
    logic [OP_W-1:0]   w_op   [TABLE_DEPTH+1];
    logic [SYM_W-1:0]  w_a1   [TABLE_DEPTH+1];
    logic [SYM_W-1:0]  w_a2   [TABLE_DEPTH+1];
    logic [SYM_W-1:0]  w_dst  [TABLE_DEPTH+1];
    logic [SLOT_W-1:0] w_slot [TABLE_DEPTH+1];
    logic [SYM_W-1:0]  w_repl [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] w_tok_vld;

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // Latched chain tail
    logic              r_res_last;
    logic              r_res_hit;
    logic [OP_W-1:0]   r_res_op;
    logic [SYM_W-1:0]  r_res_a1;
    logic [SYM_W-1:0]  r_res_a2;
    logic [SYM_W-1:0]  r_res_dst;
    logic [SLOT_W-1:0] r_res_slot;
    logic [SYM_W-1:0]  r_res_repl;

    // Output register
    logic              r_out_vld;
    logic              n_out_vld;
    logic              r_kept;
    logic              r_matched;
    logic [SLOT_W-1:0] r_slot;
    logic [SYM_W-1:0]  r_repl;
    logic              r_ovf;
    logic [OP_W-1:0]   r_op;
    logic [SYM_W-1:0]  r_a1;
    logic [SYM_W-1:0]  r_a2;
    logic [SYM_W-1:0]  r_dst;

    logic              w_accept;
    logic              w_tail_vld;
    logic              w_commit;
    logic              w_full;
    logic              w_wr_en;
    logic [SLOT_W-1:0] w_new_slot;
    logic [SLOT_W+SLOT_PORT_W-1:0] w_slot_ext;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_ctl[0]  = '{vld: w_accept, last: i_last_item, hit: 1'b0};
    assign w_op[0]   = i_opcode_id;
    assign w_a1[0]   = i_first_arg[SYM_W-1:0];
    assign w_a2[0]   = i_second_arg[SYM_W-1:0];
    assign w_dst[0]  = i_dest_name[SYM_W-1:0];
    assign w_slot[0] = '0;
    assign w_repl[0] = '0;

    assign w_full     = (r_count >= CNT_W'(TABLE_DEPTH));
    assign w_commit   = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);
    assign w_wr_en    = w_commit && !r_res_hit && !w_full;
    assign w_new_slot = w_full ? '0 : r_count[SLOT_W-1:0];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        qdt_cell #(
            .SYM_W  (SYM_W),
            .SLOT_W (SLOT_W),
            .CNT_W  (CNT_W),
            .IDX    (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_count   (r_count),
            .i_wr_en   (w_wr_en),
            .i_wr_slot (w_new_slot),
            .i_wr_op   (r_res_op),
            .i_wr_a1   (r_res_a1),
            .i_wr_a2   (r_res_a2),
            .i_wr_dst  (r_res_dst),
            .i_ctl     (w_ctl[g]),
            .i_op      (w_op[g]),
            .i_a1      (w_a1[g]),
            .i_a2      (w_a2[g]),
            .i_dst     (w_dst[g]),
            .i_slot    (w_slot[g]),
            .i_repl    (w_repl[g]),
            .o_ctl     (w_ctl[g+1]),
            .o_op      (w_op[g+1]),
            .o_a1      (w_a1[g+1]),
            .o_a2      (w_a2[g+1]),
            .o_dst     (w_dst[g+1]),
            .o_slot    (w_slot[g+1]),
            .o_repl    (w_repl[g+1])
        );
        assign w_tok_vld[g] = w_ctl[g+1].vld;
    end

    assign w_tail_vld = w_ctl[TABLE_DEPTH].vld;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept)   n_state = S_RUN;
            S_RUN:   if (w_tail_vld) n_state = S_DONE;
            S_DONE:  if (w_commit)   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_wr_en) begin
            n_count = r_count + CNT_W'(1);
        end
        // Drop the whole table once the block's last item is committed
        if (w_commit && r_res_last) begin
            n_count = '0;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_commit) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RUN) && w_tail_vld) begin
            r_res_last <= w_ctl[TABLE_DEPTH].last;
            r_res_hit  <= w_ctl[TABLE_DEPTH].hit;
            r_res_op   <= w_op[TABLE_DEPTH];
            r_res_a1   <= w_a1[TABLE_DEPTH];
            r_res_a2   <= w_a2[TABLE_DEPTH];
            r_res_dst  <= w_dst[TABLE_DEPTH];
            r_res_slot <= w_slot[TABLE_DEPTH];
            r_res_repl <= w_repl[TABLE_DEPTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_kept    <= !r_res_hit;
            r_matched <= r_res_hit;
            r_slot    <= r_res_hit ? r_res_slot : w_new_slot;
            r_repl    <= r_res_hit ? r_res_repl : r_res_dst;
            r_ovf     <= !r_res_hit && w_full;
            r_op      <= r_res_op;
            r_a1      <= r_res_a1;
            r_a2      <= r_res_a2;
            r_dst     <= r_res_dst;
        end
    end

    // Widen first so the low bits of the slot land in the field at any depth
    assign w_slot_ext = {{SLOT_PORT_W{1'b0}}, r_slot};

    assign o_out_valid      = r_out_vld;
    assign o_kept           = r_kept;
    assign o_matched        = r_matched;
    assign o_match_slot     = w_slot_ext[SLOT_PORT_W-1:0];
    assign o_replace_with   = SYM_PORT_W'(r_repl);
    assign o_table_overflow = r_ovf;
    assign o_out_opcode     = r_op;
    assign o_out_first_arg  = SYM_PORT_W'(r_a1);
    assign o_out_second_arg = SYM_PORT_W'(r_a2);
    assign o_out_dest       = SYM_PORT_W'(r_dst);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vld))
        else $error("more than one lookup token in the chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(|w_tok_vld))
        else $error("token in chain while idle");

    a_insert_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && !r_res_last) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not advance fill count");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_res_last) |=> (r_count == '0))
        else $error("last item did not empty the table");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for quad_dedup_table: random and directed quadruple streams.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qdt_pkg::*;

    localparam int TBL_DEPTH  = 128;
    localparam int SYM_BITS   = 8;
    localparam int ITEM_GOAL  = 500;
    localparam int IDLE_PCT   = 13;
    localparam int QUIET_FROM = 30000;
    localparam int QUIET_TO   = 42000;
    localparam int HOLD_AT    = 3000;
    localparam int HOLD_LEN   = 700;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [SYM_PORT_W-1:0] a1;
        logic [SYM_PORT_W-1:0] a2;
        logic [SYM_PORT_W-1:0] dst;
        logic                  last;
    } t_quad;

    typedef struct packed {
        logic                   kept;
        logic                   matched;
        logic [SLOT_PORT_W-1:0] slot;
        logic [SYM_PORT_W-1:0]  repl;
        logic                   ovf;
        logic [OP_W-1:0]        op;
        logic [SYM_PORT_W-1:0]  a1;
        logic [SYM_PORT_W-1:0]  a2;
        logic [SYM_PORT_W-1:0]  dst;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [OP_W-1:0]        in_opcode = '0;
    logic [SYM_PORT_W-1:0]  in_first = '0;
    logic [SYM_PORT_W-1:0]  in_second = '0;
    logic [SYM_PORT_W-1:0]  in_dest = '0;
    logic                   in_last = 1'b0;

    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   out_kept;
    logic                   out_matched;
    logic [SLOT_PORT_W-1:0] out_slot;
    logic [SYM_PORT_W-1:0]  out_repl;
    logic                   out_ovf;
    logic [OP_W-1:0]        out_opcode;
    logic [SYM_PORT_W-1:0]  out_first;
    logic [SYM_PORT_W-1:0]  out_second;
    logic [SYM_PORT_W-1:0]  out_dest;

    quad_dedup_table #(
        .TABLE_DEPTH (TBL_DEPTH),
        .SYMBOL_BITS (SYM_BITS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode_id      (in_opcode),
        .i_first_arg      (in_first),
        .i_second_arg     (in_second),
        .i_dest_name      (in_dest),
        .i_last_item      (in_last),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_kept           (out_kept),
        .o_matched        (out_matched),
        .o_match_slot     (out_slot),
        .o_replace_with   (out_repl),
        .o_table_overflow (out_ovf),
        .o_out_opcode     (out_opcode),
        .o_out_first_arg  (out_first),
        .o_out_second_arg (out_second),
        .o_out_dest       (out_dest)
    );

    t_quad    pending_quads[$];
    t_outcome expected_outcomes[$];
    t_quad    offered;
    int       quads_total = 0;
    int       quads_accepted = 0;
    int       mismatches = 0;
    int       cyc = 0;
    int       hold_left = 0;

    // Shadow copy of the subexpression table
    t_quad    cse_table[TBL_DEPTH];
    int       cse_fill = 0;

    function automatic t_outcome cse_lookup(t_quad q);
        t_outcome r;
        int       hit_at;
        hit_at    = -1;
        r.kept    = 1'b1;
        r.matched = 1'b0;
        r.slot    = '0;
        r.repl    = q.dst;
        r.ovf     = 1'b0;
        r.op      = q.op;
        r.a1      = q.a1;
        r.a2      = q.a2;
        r.dst     = q.dst;
        for (int j = 0; j < cse_fill; j++) begin
            if (hit_at < 0 && cse_table[j].op == q.op && cse_table[j].a1 == q.a1 &&
                cse_table[j].a2 == q.a2)
                hit_at = j;
        end
        if (hit_at >= 0) begin
            r.kept    = 1'b0;
            r.matched = 1'b1;
            r.slot    = SLOT_PORT_W'(hit_at);
            r.repl    = cse_table[hit_at].dst;
        end else if (cse_fill < TBL_DEPTH) begin
            cse_table[cse_fill] = q;
            r.slot   = SLOT_PORT_W'(cse_fill);
            cse_fill = cse_fill + 1;
        end else begin
            r.ovf = 1'b1;
        end
        if (q.last)
            cse_fill = 0;
        return r;
    endfunction

    function automatic void add_quad(int op, int a1, int a2, int dst, bit last);
        t_quad q;
        q.op   = OP_W'(op);
        q.a1   = SYM_PORT_W'(a1);
        q.a2   = SYM_PORT_W'(a2);
        q.dst  = SYM_PORT_W'(dst);
        q.last = last;
        pending_quads.push_back(q);
        quads_total++;
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    function automatic bit idle_now();
        return !(cyc >= QUIET_FROM && cyc < QUIET_TO) && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Generous simulation timeout cap
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // Long receiver hold-off so the block fills and stalls its input
    always @(posedge i_clk) begin
        if (cyc == HOLD_AT)
            hold_left <= HOLD_LEN;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_outcomes.push_back(cse_lookup(offered));
                quads_accepted++;
            end
            // hold a stalled transfer, otherwise offer the next item or idle
            if (!in_valid || !in_stall) begin
                if (pending_quads.size() > 0 && !idle_now()) begin
                    offered = pending_quads.pop_front();
                    in_valid  <= 1'b1;
                    in_opcode <= offered.op;
                    in_first  <= offered.a1;
                    in_second <= offered.a2;
                    in_dest   <= offered.dst;
                    in_last   <= offered.last;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        out_stall <= (hold_left != 0) || idle_now();
    end

    // Monitor
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none actual dest %0h",
                         $time, out_dest);
                mismatches++;
            end else begin
                want = expected_outcomes.pop_front();
                check_field("kept", want.kept, out_kept);
                check_field("matched", want.matched, out_matched);
                check_field("match_slot", want.slot, out_slot);
                check_field("replace_with", want.repl, out_repl);
                check_field("table_overflow", want.ovf, out_ovf);
                check_field("out_opcode", want.op, out_opcode);
                check_field("out_first_arg", want.a1, out_first);
                check_field("out_second_arg", want.a2, out_second);
                check_field("out_dest", want.dst, out_dest);
            end
        end
    end

    initial begin : stimulus
        t_quad                 long_trips[TBL_DEPTH];
        logic [SYM_PORT_W-1:0] pool[4];
        logic [OP_W-1:0]       ops[2];
        int                    kind;
        int                    len;
        int                    extra;
        int                    pick;
        int                    long_blocks;
        long_blocks = 0;

        // Directed: field extremes, hits, misses, argument order, table clearing
        add_quad(0, 8'h00, 8'h00, 8'h00, 0);
        add_quad(0, 8'h00, 8'h00, 8'hff, 0);
        add_quad(15, 8'hff, 8'hff, 8'haa, 0);
        add_quad(15, 8'hff, 8'hff, 8'h55, 0);
        add_quad(0, 8'h00, 8'h01, 8'h10, 0);
        add_quad(0, 8'h01, 8'h00, 8'h11, 0);
        add_quad(1, 8'h00, 8'h00, 8'h12, 0);
        add_quad(2, 8'h03, 8'h04, 8'h13, 0);
        add_quad(2, 8'h04, 8'h03, 8'h14, 0);
        add_quad(2, 8'h03, 8'h04, 8'h15, 0);
        add_quad(0, 8'h00, 8'h00, 8'h16, 1);
        add_quad(0, 8'h00, 8'h00, 8'h34, 0);
        add_quad(5, 8'ha5, 8'h5a, 8'h77, 1);
        add_quad(5, 8'ha5, 8'h5a, 8'h78, 1);
        add_quad(10, 8'h80, 8'h7f, 8'hc3, 0);
        add_quad(10, 8'h80, 8'h7f, 8'h3c, 0);
        add_quad(10, 8'h80, 8'h7f, 8'h99, 1);

        while (quads_total < ITEM_GOAL) begin
            kind = $urandom_range(0, 99);
            if ((kind < 8 && long_blocks < 2) ||
                (long_blocks == 0 && quads_total > ITEM_GOAL / 2)) begin
                // fill the table past its depth, then mix overflow misses and hits
                long_blocks++;
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    long_trips[i].op  = OP_W'($urandom_range(0, 15));
                    long_trips[i].a1  = SYM_PORT_W'(i);
                    long_trips[i].a2  = SYM_PORT_W'($urandom_range(0, 255));
                    long_trips[i].dst = SYM_PORT_W'($urandom_range(0, 255));
                    add_quad(long_trips[i].op, long_trips[i].a1, long_trips[i].a2,
                             long_trips[i].dst, 0);
                end
                extra = $urandom_range(4, 14);
                for (int k = 0; k < extra; k++) begin
                    if ($urandom_range(0, 1)) begin
                        add_quad($urandom_range(0, 15), 128 + k, $urandom_range(0, 255),
                                 $urandom_range(0, 255), k == extra - 1);
                    end else begin
                        pick = $urandom_range(0, TBL_DEPTH - 1);
                        add_quad(long_trips[pick].op, long_trips[pick].a1,
                                 long_trips[pick].a2, $urandom_range(0, 255),
                                 k == extra - 1);
                    end
                end
            end else if (kind < 18) begin
                // noise: unconstrained items, the mark set at random
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                    add_quad($urandom_range(0, 15), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 3) == 0);
            end else begin
                // short basic block drawn from small symbol pools to force repeats
                for (int k = 0; k < 4; k++)
                    pool[k] = SYM_PORT_W'($urandom_range(0, 255));
                ops[0] = OP_W'($urandom_range(0, 15));
                ops[1] = OP_W'($urandom_range(0, 15));
                len = $urandom_range(1, 24);
                for (int k = 0; k < len; k++)
                    add_quad(ops[$urandom_range(0, 1)], pool[$urandom_range(0, 3)],
                             pool[$urandom_range(0, 3)], $urandom_range(0, 255),
                             k == len - 1);
            end
        end

        while (quads_accepted != quads_total)
            @(posedge i_clk);
        while (expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (2 * (TBL_DEPTH + 2)) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
